>>> hdl/point_segment_distance_squared_core_defines.svh
// assertion macros shared by the core
`ifndef POINT_SEGMENT_DISTANCE_SQUARED_CORE_DEFINES_SVH
`define POINT_SEGMENT_DISTANCE_SQUARED_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");
// consequent a fixed number of cycles later
`define ASSERT_DELAY(label, clk, rst, ante, dly, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error("assertion failed: delayed implication");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_DELAY(label, clk, rst, ante, dly, cons)
`endif

`endif

>>> hdl/psd_pkg.sv
`default_nettype none

package psd_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int FRAC_BITS_DEF = 8;
   localparam int RADIUS_BITS = 12;
   localparam int DIST_BITS = 33;

   localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 12'd15;
   localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

   // per-transaction control that rides along the divider
   typedef struct packed {
      logic valid;
      logic endpoint;
      logic hit;
   } psd_ctl_type;

endpackage

`default_nettype wire

>>> hdl/psd_geom.sv
`default_nettype none

module psd_geom import psd_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            in_valid,
   input  wire logic [COORD_BITS-1:0]           start_x,
   input  wire logic [COORD_BITS-1:0]           start_y,
   input  wire logic [COORD_BITS-1:0]           end_x,
   input  wire logic [COORD_BITS-1:0]           end_y,
   input  wire logic [COORD_BITS-1:0]           point_x,
   input  wire logic [COORD_BITS-1:0]           point_y,
   output logic                                 out_valid,
   output logic [2*COORD_BITS:0]                len_sq,
   output logic signed [2*COORD_BITS+1:0]       dot,
   output logic signed [2*COORD_BITS+1:0]       cross_prod,
   output logic [2*COORD_BITS:0]                dist_start,
   output logic [2*COORD_BITS:0]                dist_end
);

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * COORD_BITS + 2;
   localparam int LW = 2 * COORD_BITS + 1;

   // stage a: coordinate differences
   logic signed [DW-1:0] wx_in, wy_in, qx_in, qy_in, ux_in, uy_in;
   logic signed [DW-1:0] wx_ff, wy_ff, qx_ff, qy_ff, ux_ff, uy_ff;
   logic                 va_ff;

   assign wx_in = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
   assign wy_in = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
   assign qx_in = $signed({1'b0, point_x}) - $signed({1'b0, start_x});
   assign qy_in = $signed({1'b0, point_y}) - $signed({1'b0, start_y});
   assign ux_in = $signed({1'b0, point_x}) - $signed({1'b0, end_x});
   assign uy_in = $signed({1'b0, point_y}) - $signed({1'b0, end_y});

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
      end
      wx_ff <= wx_in;
      wy_ff <= wy_in;
      qx_ff <= qx_in;
      qy_ff <= qy_in;
      ux_ff <= ux_in;
      uy_ff <= uy_in;
   end

   // stage b: products
   logic signed [PW-1:0] wxwx_in, wywy_in, qxwx_in, qywy_in, qxwy_in;
   logic signed [PW-1:0] qywx_in, qxqx_in, qyqy_in, uxux_in, uyuy_in;
   logic signed [PW-1:0] wxwx_ff, wywy_ff, qxwx_ff, qywy_ff, qxwy_ff;
   logic signed [PW-1:0] qywx_ff, qxqx_ff, qyqy_ff, uxux_ff, uyuy_ff;
   logic                 vb_ff;

   assign wxwx_in = wx_ff * wx_ff;
   assign wywy_in = wy_ff * wy_ff;
   assign qxwx_in = qx_ff * wx_ff;
   assign qywy_in = qy_ff * wy_ff;
   assign qxwy_in = qx_ff * wy_ff;
   assign qywx_in = qy_ff * wx_ff;
   assign qxqx_in = qx_ff * qx_ff;
   assign qyqy_in = qy_ff * qy_ff;
   assign uxux_in = ux_ff * ux_ff;
   assign uyuy_in = uy_ff * uy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else begin
         vb_ff <= va_ff;
      end
      wxwx_ff <= wxwx_in;
      wywy_ff <= wywy_in;
      qxwx_ff <= qxwx_in;
      qywy_ff <= qywy_in;
      qxwy_ff <= qxwy_in;
      qywx_ff <= qywx_in;
      qxqx_ff <= qxqx_in;
      qyqy_ff <= qyqy_in;
      uxux_ff <= uxux_in;
      uyuy_ff <= uyuy_in;
   end

   // stage c: sums
   logic [PW-1:0]        l2_sum, ds_sum, de_sum;
   logic [LW-1:0]        l2_in, ds_in, de_in;
   logic signed [PW-1:0] dot_in, cross_in;
   logic [LW-1:0]        l2_ff, ds_ff, de_ff;
   logic signed [PW-1:0] dot_ff, cross_ff;
   logic                 vc_ff;

   assign l2_sum   = wxwx_ff + wywy_ff;
   assign ds_sum   = qxqx_ff + qyqy_ff;
   assign de_sum   = uxux_ff + uyuy_ff;
   assign l2_in    = l2_sum[LW-1:0];
   assign ds_in    = ds_sum[LW-1:0];
   assign de_in    = de_sum[LW-1:0];
   assign dot_in   = qxwx_ff + qywy_ff;
   assign cross_in = qxwy_ff - qywx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else begin
         vc_ff <= vb_ff;
      end
      l2_ff    <= l2_in;
      ds_ff    <= ds_in;
      de_ff    <= de_in;
      dot_ff   <= dot_in;
      cross_ff <= cross_in;
   end

   assign out_valid  = vc_ff;
   assign len_sq     = l2_ff;
   assign dot        = dot_ff;
   assign cross_prod = cross_ff;
   assign dist_start = ds_ff;
   assign dist_end   = de_ff;

endmodule

`default_nettype wire

>>> hdl/psd_classify.sv
`default_nettype none

module psd_classify import psd_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            in_valid,
   input  wire logic [2*COORD_BITS:0]           len_sq,
   input  wire logic signed [2*COORD_BITS+1:0]  dot,
   input  wire logic signed [2*COORD_BITS+1:0]  cross_prod,
   input  wire logic [2*COORD_BITS:0]           dist_start,
   input  wire logic [2*COORD_BITS:0]           dist_end,
   input  wire logic [2*RADIUS_BITS-1:0]        radius_sq,
   output psd_ctl_type                          ctl,
   output logic [2*COORD_BITS:0]                div_len_sq,
   output logic [4*COORD_BITS+1:0]              cross_sq,
   output logic [2*COORD_BITS:0]                dist_ep
);

   localparam int PW  = 2 * COORD_BITS + 2;
   localparam int LW  = 2 * COORD_BITS + 1;
   localparam int R2W = 2 * RADIUS_BITS;
   localparam int RLW = R2W + LW;
   localparam int CW  = (LW > R2W) ? LW : R2W;
   localparam int HW  = (2 * LW > RLW) ? 2 * LW : RLW;

   // stage d: pick the case
   logic                 near_start, near_end;
   logic signed [PW-1:0] cross_neg;
   logic [LW-1:0]        acr_in, dep_in;
   logic [LW-1:0]        acr_ff, dep_ff, l2d_ff;
   logic                 vd_ff, epd_ff;

   assign near_start = (len_sq == '0) || dot[PW-1];
   assign near_end   = !near_start && (dot > $signed({1'b0, len_sq}));
   assign cross_neg  = -cross_prod;
   assign acr_in     = cross_prod[PW-1] ? cross_neg[LW-1:0] : cross_prod[LW-1:0];
   assign dep_in     = near_start ? dist_start : dist_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
      end else begin
         vd_ff <= in_valid;
      end
      epd_ff <= near_start || near_end;
      acr_ff <= acr_in;
      dep_ff <= dep_in;
      l2d_ff <= len_sq;
   end

   // stage e: squares for the perpendicular case, radius compare for the endpoint case
   logic [2*LW-1:0] c2_in;
   logic [RLW-1:0]  rl_in;
   logic            eph_in;
   logic [2*LW-1:0] c2_ff;
   logic [RLW-1:0]  rl_ff;
   logic [LW-1:0]   dep_e_ff, l2e_ff;
   logic            ve_ff, epe_ff, eph_ff;

   assign c2_in  = acr_ff * acr_ff;
   assign rl_in  = RLW'(radius_sq) * RLW'(l2d_ff);
   assign eph_in = CW'(dep_ff) < CW'(radius_sq);

   always_ff @(posedge clock) begin
      if (reset) begin
         ve_ff <= 1'b0;
      end else begin
         ve_ff <= vd_ff;
      end
      epe_ff   <= epd_ff;
      eph_ff   <= eph_in;
      c2_ff    <= c2_in;
      rl_ff    <= rl_in;
      dep_e_ff <= dep_ff;
      l2e_ff   <= l2d_ff;
   end

   // stage f: exact hit test
   // cross^2 / len^2 < r^2 rewritten without the division
   logic            hit_in;
   psd_ctl_type     ctl_ff;
   logic [2*LW-1:0] c2f_ff;
   logic [LW-1:0]   depf_ff, l2f_ff;

   assign hit_in = epe_ff ? eph_ff : (HW'(c2_ff) < HW'(rl_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff.valid    <= ve_ff;
         ctl_ff.endpoint <= epe_ff;
         ctl_ff.hit      <= hit_in;
      end
      c2f_ff  <= c2_ff;
      depf_ff <= dep_e_ff;
      l2f_ff  <= l2e_ff;
   end

   assign ctl        = ctl_ff;
   assign div_len_sq = l2f_ff;
   assign cross_sq   = c2f_ff;
   assign dist_ep    = depf_ff;

endmodule

`default_nettype wire

>>> hdl/psd_div.sv
`default_nettype none

module psd_div import psd_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire psd_ctl_type                ctl,
   input  wire logic [2*COORD_BITS:0]      div_len_sq,
   input  wire logic [4*COORD_BITS+1:0]    cross_sq,
   input  wire logic [2*COORD_BITS:0]      dist_ep,
   output logic                            out_valid,
   output logic [DIST_BITS-1:0]            out_dist_sq,
   output logic                            out_hit
);

   localparam int LW = 2 * COORD_BITS + 1;
   localparam int QB = LW + FRAC_BITS;
   localparam int NW = 2 * LW + FRAC_BITS;
   localparam int XW = (QB > DIST_BITS) ? QB : DIST_BITS;
   localparam logic [XW-1:0] DIST_LIMIT = XW'(DIST_MAX);

   logic [NW-1:0] num_full;

   // one quotient bit per stage, restoring
   logic [LW-1:0] rem_ff [0:QB];
   logic [QB-1:0] num_ff [0:QB];
   logic [QB-1:0] quo_ff [0:QB];
   logic [LW-1:0] den_ff [0:QB];
   logic [LW-1:0] dep_ff [0:QB];
   psd_ctl_type   ctl_ff [0:QB];

   assign num_full = NW'(cross_sq) << FRAC_BITS;

   // the quotient fits QB bits, so the top LW numerator bits are already below the divisor
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else begin
         ctl_ff[0] <= ctl;
      end
      rem_ff[0] <= num_full[NW-1 -: LW];
      num_ff[0] <= num_full[QB-1:0];
      quo_ff[0] <= '0;
      den_ff[0] <= div_len_sq;
      dep_ff[0] <= dist_ep;
   end

   for (genvar k = 1; k <= QB; k++) begin : g_step
      logic [LW:0]   trial;
      logic [LW:0]   diff;
      logic          ge;
      logic [LW-1:0] rem_in;

      assign trial  = {rem_ff[k-1], num_ff[k-1][QB-1]};
      assign diff   = trial - {1'b0, den_ff[k-1]};
      assign ge     = trial >= {1'b0, den_ff[k-1]};
      assign rem_in = ge ? diff[LW-1:0] : trial[LW-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k] <= '0;
         end else begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
         rem_ff[k] <= rem_in;
         num_ff[k] <= num_ff[k-1] << 1;
         quo_ff[k] <= (quo_ff[k-1] << 1) | QB'(ge);
         den_ff[k] <= den_ff[k-1];
         dep_ff[k] <= dep_ff[k-1];
      end
   end

   // output: endpoint or quotient, clamped to the field
   logic [QB-1:0]        dist_sel;
   logic [XW-1:0]        dist_ext;
   logic [DIST_BITS-1:0] dist_in;
   logic                 valid_ff, hit_ff;
   logic [DIST_BITS-1:0] dist_ff;

   assign dist_sel = ctl_ff[QB].endpoint ? (QB'(dep_ff[QB]) << FRAC_BITS) : quo_ff[QB];
   assign dist_ext = XW'(dist_sel);
   assign dist_in  = (dist_ext > DIST_LIMIT) ? DIST_MAX : dist_ext[DIST_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctl_ff[QB].valid;
      end
      hit_ff  <= ctl_ff[QB].hit;
      dist_ff <= dist_in;
   end

   assign out_valid   = valid_ff;
   assign out_dist_sq = dist_ff;
   assign out_hit     = hit_ff;

endmodule

`default_nettype wire

>>> hdl/point_segment_distance_squared_core.sv
// Squared distance from a point to a line segment, with a radius hit test.
// A transaction is taken on every clock edge where start is high and busy is
// low; busy is high only during reset and in the cycle after it, so a new
// transaction can enter every cycle. The result is strobed on rsp_valid for
// exactly one cycle, and the receiver cannot hold it off. The divider produces
// one quotient bit per pipeline stage. Results come out in order. dist_sq
// carries FRAC_BITS fraction bits, truncated; hit compares the exact distance
// against the csr_wr_data radius squared. Write csr_wr_data only while no
// transaction is in flight; it resets to 15.
`default_nettype none

`include "point_segment_distance_squared_core_defines.svh"

module point_segment_distance_squared_core import psd_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic [COORD_BITS-1:0]   req_start_x,
   input  wire logic [COORD_BITS-1:0]   req_start_y,
   input  wire logic [COORD_BITS-1:0]   req_end_x,
   input  wire logic [COORD_BITS-1:0]   req_end_y,
   input  wire logic [COORD_BITS-1:0]   req_point_x,
   input  wire logic [COORD_BITS-1:0]   req_point_y,
   input  wire logic                    csr_wr_en,
   input  wire logic [RADIUS_BITS-1:0]  csr_wr_data,
   output logic                         rsp_valid,
   output logic [DIST_BITS-1:0]         rsp_dist_sq,
   output logic                         rsp_hit
);

   localparam int PW      = 2 * COORD_BITS + 2;
   localparam int LW      = 2 * COORD_BITS + 1;
   localparam int R2W     = 2 * RADIUS_BITS;
   localparam int LATENCY = LW + FRAC_BITS + 8;
   localparam int BW      = (DIST_BITS > R2W + FRAC_BITS) ? DIST_BITS : R2W + FRAC_BITS;
   localparam logic [R2W-1:0] R2_RESET = R2W'(RADIUS_RESET) * R2W'(RADIUS_RESET);

   logic           busy_ff;
   logic           accept;
   logic [R2W-1:0] r2_in, r2_ff;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;
   assign r2_in  = R2W'(csr_wr_data) * R2W'(csr_wr_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         r2_ff   <= R2_RESET;
      end else begin
         busy_ff <= 1'b0;
         if (csr_wr_en) begin
            r2_ff <= r2_in;
         end
      end
   end

   logic                 g_valid;
   logic [LW-1:0]        g_len_sq, g_dist_start, g_dist_end;
   logic signed [PW-1:0] g_dot, g_cross;

   psd_geom #(
      .COORD_BITS(COORD_BITS)
   ) u_geom (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .start_x    (req_start_x),
      .start_y    (req_start_y),
      .end_x      (req_end_x),
      .end_y      (req_end_y),
      .point_x    (req_point_x),
      .point_y    (req_point_y),
      .out_valid  (g_valid),
      .len_sq     (g_len_sq),
      .dot        (g_dot),
      .cross_prod (g_cross),
      .dist_start (g_dist_start),
      .dist_end   (g_dist_end)
   );

   psd_ctl_type     c_ctl;
   logic [LW-1:0]   c_len_sq, c_dist_ep;
   logic [2*LW-1:0] c_cross_sq;

   psd_classify #(
      .COORD_BITS(COORD_BITS)
   ) u_classify (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (g_valid),
      .len_sq     (g_len_sq),
      .dot        (g_dot),
      .cross_prod (g_cross),
      .dist_start (g_dist_start),
      .dist_end   (g_dist_end),
      .radius_sq  (r2_ff),
      .ctl        (c_ctl),
      .div_len_sq (c_len_sq),
      .cross_sq   (c_cross_sq),
      .dist_ep    (c_dist_ep)
   );

   psd_div #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .ctl         (c_ctl),
      .div_len_sq  (c_len_sq),
      .cross_sq    (c_cross_sq),
      .dist_ep     (c_dist_ep),
      .out_valid   (rsp_valid),
      .out_dist_sq (rsp_dist_sq),
      .out_hit     (rsp_hit)
   );

   // truncation cannot move a distance across the integer bound r^2 << FRAC_BITS
   logic hit_below;

   assign hit_below = BW'(rsp_dist_sq) < (BW'(r2_ff) << FRAC_BITS);

   `ASSERT_DELAY(a_result_latency, clock, reset, accept, LATENCY, rsp_valid)
   `ASSERT_IMPLY(a_result_has_source, clock, reset, rsp_valid, $past(accept, LATENCY))
   `ASSERT_IMPLY(a_hit_vs_dist, clock, reset, rsp_valid && (rsp_dist_sq != DIST_MAX), rsp_hit == hit_below)

endmodule

`default_nettype wire
